[rtl/y2r_pkg.sv]
// ----------------------------------------------------------------------------
// y2r_pkg : shared types and constants of the 4:2:0 block colour converter
// Full-range BT.601 coefficients in signed Q2.14, plus the sum and clamp
// helpers used by the pipeline.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned FracW = 14;
  localparam int unsigned DiffW = PixW + 1;       // signed chroma difference
  localparam int unsigned CoefW = 16;             // signed holder of a Q2.14 coefficient
  localparam int unsigned SumW  = DiffW + CoefW;  // fixed-point sum width

  localparam int unsigned NumLuma = 4;
  localparam int unsigned InW     = 6 * PixW;
  localparam int unsigned OutW    = 3 * NumLuma * PixW;

  // Coefficients, Q2.14; CoefRCr rounded up, the others rounded to nearest
  localparam logic signed [CoefW-1:0] CoefRCr = 16'sd22971;  // 1.402
  localparam logic signed [CoefW-1:0] CoefGCb = 16'sd5636;   // 0.344
  localparam logic signed [CoefW-1:0] CoefGCr = 16'sd11698;  // 0.714
  localparam logic signed [CoefW-1:0] CoefBCb = 16'sd29032;  // 1.772

  typedef logic [PixW-1:0]         pix_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // Remove the chroma offset of 128: flip the top bit and sign-extend
  function automatic diff_t chroma_diff(input pix_t c);
    return {~c[PixW-1], ~c[PixW-1], c[PixW-2:0]};
  endfunction

  // Place a luma sample at the binary point of the sum
  function automatic sum_t luma_base(input pix_t y);
    return {{(SumW-PixW-FracW){1'b0}}, y, {FracW{1'b0}}};
  endfunction

  // Truncate toward zero and clamp to 0..255; negative sums give zero
  function automatic pix_t clamp_pix(input sum_t s);
    pix_t r;
    if (s[SumW-1]) begin
      r = '0;
    end else if (|s[SumW-2:FracW+PixW]) begin
      r = '1;
    end else begin
      r = s[FracW+PixW-1:FracW];
    end
    return r;
  endfunction

endpackage

[rtl/yuv420_block_to_rgb.sv]
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb : 2x2 luma block plus shared Cb/Cr to four RGB pixels
// Full-range BT.601 conversion in Q2.14 fixed point, four register stages.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields, lowest bits first
//  s_axis   | in  | luma_top_left, luma_top_right, luma_bottom_left,
//           |     | luma_bottom_right, blue_diff, red_diff (8 bits each)
//  m_axis   | out | red/green/blue of tl, tr, bl, br pixel (8 bits each)
//
// One block per cycle sustained while m_axis is not stalled; a block passes
// through four register stages (chroma offset, coefficient products, per-pixel
// sums, clamp into the output register) on its way to m_axis.
// Reset clears only the stage valid bits. A stall on m_axis holds the full
// stages; empty stages still fill, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // blue_diff, red_diff
  input  logic [y2r_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // red_tl, green_tl, blue_tl, red_tr, green_tr, blue_tr,
  // red_bl, green_bl, blue_bl, red_br, green_br, blue_br
  output logic [y2r_pkg::OutW-1:0]  m_axis_tdata
);

  localparam int unsigned NL = y2r_pkg::NumLuma;
  localparam int unsigned PW = y2r_pkg::PixW;

  // Stage valid bits and advance enables
  logic [3:0] vld_q, vld_d;
  logic [3:0] adv;

  always_comb begin
    adv[3] = !vld_q[3] || m_axis_tready;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[3];

  always_comb begin
    vld_d[0] = adv[0] ? s_axis_tvalid : vld_q[0];
    vld_d[1] = adv[1] ? vld_q[0]      : vld_q[1];
    vld_d[2] = adv[2] ? vld_q[1]      : vld_q[2];
    vld_d[3] = adv[3] ? vld_q[2]      : vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: capture lumas and remove the chroma offset
  y2r_pkg::pix_t  s1_luma_q [NL];
  y2r_pkg::diff_t s1_cb_q, s1_cr_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int i = 0; i < NL; i++) begin
        s1_luma_q[i] <= s_axis_tdata[i*PW +: PW];
      end
      s1_cb_q <= y2r_pkg::chroma_diff(s_axis_tdata[NL*PW +: PW]);
      s1_cr_q <= y2r_pkg::chroma_diff(s_axis_tdata[(NL+1)*PW +: PW]);
    end
  end

  // Stage 2: the four coefficient products, shared by all pixels
  y2r_pkg::pix_t s2_luma_q [NL];
  y2r_pkg::sum_t s2_r_cr_q, s2_g_cb_q, s2_g_cr_q, s2_b_cb_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_luma_q <= s1_luma_q;
      s2_r_cr_q <= s1_cr_q * y2r_pkg::CoefRCr;
      s2_g_cb_q <= s1_cb_q * y2r_pkg::CoefGCb;
      s2_g_cr_q <= s1_cr_q * y2r_pkg::CoefGCr;
      s2_b_cb_q <= s1_cb_q * y2r_pkg::CoefBCb;
    end
  end

  // Stage 3: per-pixel fixed-point sums
  y2r_pkg::sum_t s3_sum_q [3*NL];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < NL; i++) begin
        s3_sum_q[3*i]   <= y2r_pkg::luma_base(s2_luma_q[i]) + s2_r_cr_q;
        s3_sum_q[3*i+1] <= y2r_pkg::luma_base(s2_luma_q[i]) - s2_g_cb_q - s2_g_cr_q;
        s3_sum_q[3*i+2] <= y2r_pkg::luma_base(s2_luma_q[i]) + s2_b_cb_q;
      end
    end
  end

  // Stage 4: clamp into the output register
  logic [y2r_pkg::OutW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int k = 0; k < 3*NL; k++) begin
        out_q[k*PW +: PW] <= y2r_pkg::clamp_pix(s3_sum_q[k]);
      end
    end
  end

  assign m_axis_tdata = out_q;

  // Checks
  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> s_axis_tready)
    else $error("input stalled while a stage is empty");

  a_hold_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !adv[2] |=> vld_q[2] && $stable(s3_sum_q[0]) && $stable(s3_sum_q[11]))
    else $error("stalled sum stage lost its contents");

  a_out_from_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[2]))
    else $error("output valid without an item in the sum stage");

endmodule
